[rtl/depq_pkg.sv]
// Package for the double-ended priority queue.
// Holds widths, operation and status codes and the request, result and cell types.
// Depends on nothing; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package depq_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 24;
	localparam int VAL_W    = 24;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 11;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP_HI = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_LO = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] prio_key;
		logic [VAL_W-1:0] payload;
	} depq_req_t;

	typedef struct packed {
		logic [VAL_W-1:0]    out_value;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} depq_rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} depq_entry_t;

	// Broadcast to every cell in the cycle that a request is carried out.
	typedef struct packed {
		logic             ins;
		logic             shl;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} depq_cmd_t;

endpackage

[rtl/double_ended_priority_queue.sv]
// Top level of the double-ended priority queue: a chain of sorted cells and the count.
// Depends on depq_pkg and depq_cell.
`timescale 1ns / 1ps

// Usage:
// A request (insert, remove highest, remove lowest) is taken at a rising edge with start
// high and busy low. busy is then high for one cycle while the request is carried out
// across the whole chain of cells at once; the result appears on result, marked by done,
// for exactly one cycle, in the cycle after busy. A new request can be taken
// at the edge that ends the done cycle, so no request is taken while another is in hand.
// The busy cycle holds the broadcast compare of the key against every cell and
// the reduction of the duplicate and highest-value flags back to the top.
// Entries are kept sorted by ascending key in cells 0 to count-1: the lowest key is always
// in cell 0 and the highest in cell count-1. Removing the lowest shifts the chain down by
// one cell; an insert shifts the cells at and above the insertion point up by one.
// Reset clears the count and the busy and done flags; cell contents need no reset, since
// a cell above the count is never read. The receiver cannot stall: every result must be
// taken in its done cycle. Operation code three is a no-op that still gives a result.
module double_ended_priority_queue #(
	parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  depq_pkg::depq_req_t   request,
	output logic                  done,
	output depq_pkg::depq_rsp_t   result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int OW = depq_pkg::OCC_W;

	logic                busy_q;
	logic                done_q;
	depq_pkg::depq_req_t req_q;
	depq_pkg::depq_rsp_t result_q;
	logic [CW-1:0]       count_q;

	depq_pkg::depq_entry_t entry_arr [CAPACITY];
	logic [CAPACITY-1:0]   ge_vec;
	logic [CAPACITY-1:0]   eq_vec;
	logic [CAPACITY-1:0]   occ_vec;
	logic [CAPACITY-1:0]   top_vec;

	depq_pkg::depq_cmd_t        cmd;
	logic                       full;
	logic                       empty;
	logic                       dup;
	logic                       ins_ok;
	logic                       lo_ok;
	logic                       hi_ok;
	logic [depq_pkg::VAL_W-1:0] top_value;
	logic [depq_pkg::VAL_W-1:0] value_d;
	logic [depq_pkg::STATUS_W-1:0] status_d;
	logic [CW-1:0]              count_d;
	logic [CW+OW-1:0]           occ_wide;

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	assign full  = (count_q >= CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign dup   = |eq_vec;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			depq_pkg::depq_entry_t left_entry;
			depq_pkg::depq_entry_t right_entry;
			logic                  left_ge;

			assign occ_vec[gi] = (CW'(gi) < count_q);
			assign top_vec[gi] = (CW'(gi) == (count_q - CW'(1))) && !empty;

			if (gi == 0) begin : g_first
				assign left_entry = '0;
				assign left_ge    = 1'b0;
			end else begin : g_inner
				assign left_entry = entry_arr[gi-1];
				assign left_ge    = ge_vec[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign right_entry = '0;
			end else begin : g_body
				assign right_entry = entry_arr[gi+1];
			end

			depq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ_vec[gi]),
				.left_ge     (left_ge),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (entry_arr[gi]),
				.ge          (ge_vec[gi]),
				.eq          (eq_vec[gi])
			);
		end
	endgenerate

	// At most one cell, the one at count-1 when the store is not empty, drives the highest value.
	always_comb begin
		top_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			top_value = top_value | (top_vec[i] ? entry_arr[i].value : '0);
		end
	end

	always_comb begin
		ins_ok   = 1'b0;
		lo_ok    = 1'b0;
		hi_ok    = 1'b0;
		value_d  = '0;
		status_d = depq_pkg::ST_OK;
		unique case (req_q.operation)
			depq_pkg::OP_INSERT: begin
				priority if (full) begin
					status_d = depq_pkg::ST_FULL;
				end else if (dup) begin
					status_d = depq_pkg::ST_DUP;
				end else begin
					ins_ok = busy_q;
				end
			end
			depq_pkg::OP_POP_HI: begin
				if (empty) begin
					status_d = depq_pkg::ST_EMPTY;
				end else begin
					hi_ok   = busy_q;
					value_d = top_value;
				end
			end
			depq_pkg::OP_POP_LO: begin
				if (empty) begin
					status_d = depq_pkg::ST_EMPTY;
				end else begin
					lo_ok   = busy_q;
					value_d = entry_arr[0].value;
				end
			end
			default: begin
			end
		endcase

		priority if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (lo_ok || hi_ok) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end

		occ_wide = {OW'(0), count_d};

		cmd.ins   = ins_ok;
		cmd.shl   = lo_ok;
		cmd.key   = req_q.prio_key;
		cmd.value = req_q.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q;
			if (busy_q) begin
				busy_q  <= 1'b0;
				count_q <= count_d;
			end else if (start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_q <= request;
		end
		if (busy_q) begin
			result_q.out_value <= value_d;
			result_q.status    <= status_d;
			result_q.occupancy <= occ_wide[OW-1:0];
		end
	end

endmodule

[rtl/depq_cell.sv]
// One slot of the sorted chain: holds a key/value pair and compares it with the broadcast key.
// Depends on depq_pkg for the entry and command types.
`timescale 1ns / 1ps

module depq_cell (
	input  logic                   clk,
	input  depq_pkg::depq_cmd_t    cmd,
	input  logic                   occupied,
	input  logic                   left_ge,
	input  depq_pkg::depq_entry_t  left_entry,
	input  depq_pkg::depq_entry_t  right_entry,
	output depq_pkg::depq_entry_t  entry,
	output logic                   ge,
	output logic                   eq
);

	depq_pkg::depq_entry_t entry_q;

	assign entry = entry_q;
	assign ge    = occupied && (entry_q.key >= cmd.key);
	assign eq    = occupied && (entry_q.key == cmd.key);

	// On insert the slots at and above the insertion point move up by one and the
	// first of them takes the new pair; writing unoccupied slots is harmless.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge || !occupied) begin
				entry_q.key   <= cmd.key;
				entry_q.value <= cmd.value;
			end
		end else if (cmd.shl) begin
			entry_q <= right_entry;
		end
	end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the double-ended priority queue: directed and random requests
// are checked against a sorted-store predictor kept in a small scoreboard class.
// Depends on depq_pkg and double_ended_priority_queue.
`timescale 1ns / 1ps

module testbench;
	import depq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// Keeps the held entries sorted by ascending key and queues the answer each
	// accepted request should produce.
	class depq_scoreboard;
		logic [KEY_W-1:0] held_keys[$];
		logic [VAL_W-1:0] held_vals[$];
		depq_rsp_t awaited[$];
		int unsigned mismatches;
		int unsigned answers;
		int unsigned status_hits[4];
		int unsigned peak;

		function int unsigned held();
			return held_keys.size();
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function logic [KEY_W-1:0] held_key(int unsigned idx);
			return held_keys[idx];
		endfunction

		function void note_request(depq_req_t req);
			depq_rsp_t rsp;
			int unsigned pos;
			rsp = '0;
			case (req.operation)
				OP_INSERT: begin
					if (held_keys.size() >= CAP) begin
						rsp.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < held_keys.size() && held_keys[pos] < req.prio_key)
							pos++;
						if (pos < held_keys.size() && held_keys[pos] == req.prio_key) begin
							rsp.status = ST_DUP;
						end else begin
							held_keys.insert(pos, req.prio_key);
							held_vals.insert(pos, req.payload);
						end
					end
				end
				OP_POP_HI, OP_POP_LO: begin
					if (held_keys.size() == 0) begin
						rsp.status = ST_EMPTY;
					end else if (req.operation == OP_POP_HI) begin
						rsp.out_value = held_vals.pop_back();
						void'(held_keys.pop_back());
					end else begin
						rsp.out_value = held_vals.pop_front();
						void'(held_keys.pop_front());
					end
				end
				default: begin
				end
			endcase
			rsp.occupancy = OCC_W'(held_keys.size());
			if (held_keys.size() > peak)
				peak = held_keys.size();
			awaited.push_back(rsp);
		endfunction

		function void check_result(depq_rsp_t got);
			depq_rsp_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: value %0h status %0d occupancy %0d",
					got.out_value, got.status, got.occupancy);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			answers++;
			status_hits[want.status]++;
			if (got.out_value !== want.out_value) begin
				$error("out_value: expected %0h, got %0h", want.out_value, got.out_value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				mismatches++;
			end
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				$error("%0d results never arrived", awaited.size());
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	depq_req_t request;
	depq_rsp_t result;

	depq_scoreboard sb = new();
	int unsigned taken;
	int unsigned sent;
	int unsigned directed_count;
	int unsigned idle_pct;

	double_ended_priority_queue #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #4 clk = ~clk;

	// Results are checked before the request taken at the same edge is noted, so the
	// expectation order follows the order in which requests were accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy) begin
				sb.note_request(request);
				taken = taken + 1;
			end
		end
	end

	function automatic depq_req_t make_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
		logic [VAL_W-1:0] v);
		depq_req_t r;
		r.operation = op;
		r.prio_key = k;
		r.payload = v;
		return r;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < idle_pct)
			gap++;
		return gap;
	endfunction

	// Mostly fresh random keys, with a share of held keys and keys near the ends of
	// the range so that duplicates and extreme orderings turn up often.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12 && sb.held() != 0)
			return sb.held_key($urandom_range(sb.held() - 1));
		else if (r < 20)
			return KEY_W'($urandom_range(7));
		else if (r < 28)
			return KEY_MAX - KEY_W'($urandom_range(7));
		return KEY_W'($urandom());
	endfunction

	function automatic depq_req_t random_req(int unsigned ins_pct);
		int unsigned r;
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] v;
		r = $urandom_range(99);
		if (r < 3)
			op = OP_NOP;
		else if (r < 3 + ins_pct)
			op = OP_INSERT;
		else if (r[0])
			op = OP_POP_HI;
		else
			op = OP_POP_LO;
		case ($urandom_range(9))
			0: v = '0;
			1: v = VAL_MAX;
			default: v = VAL_W'($urandom());
		endcase
		return make_req(op, pick_key(), v);
	endfunction

	task automatic issue(input depq_req_t r);
		int unsigned gap;
		int unsigned target;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		target = taken + 1;
		wait (taken == target);
		sent++;
	endtask

	// Holds the sender off until every awaited result is in, then lets the chain settle.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_mix(input int unsigned n, input int unsigned ins_pct);
		repeat (n) issue(random_req(ins_pct));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		taken = 0;
		sent = 0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: removals and the no-op on an empty store, key and payload extremes,
		// duplicates, then draining from both ends past empty.
		issue(make_req(OP_POP_HI, KEY_MAX, VAL_MAX));
		issue(make_req(OP_POP_LO, '0, VAL_MAX));
		issue(make_req(OP_NOP, KEY_MAX, VAL_MAX));
		issue(make_req(OP_INSERT, '0, VAL_MAX));
		issue(make_req(OP_INSERT, KEY_MAX, '0));
		issue(make_req(OP_INSERT, '0, 24'h123456));
		issue(make_req(OP_INSERT, KEY_MAX, 24'h654321));
		issue(make_req(OP_INSERT, 24'h800000, 24'h555555));
		issue(make_req(OP_INSERT, 24'h7FFFFF, 24'hAAAAAA));
		issue(make_req(OP_INSERT, 24'h000001, 24'h000001));
		issue(make_req(OP_INSERT, 24'hFFFFFE, 24'hFFFFFE));
		issue(make_req(OP_NOP, 24'h800000, 24'h555555));
		issue(make_req(OP_POP_HI, 24'h5A5A5A, 24'hA5A5A5));
		issue(make_req(OP_POP_LO, 24'hA5A5A5, 24'h5A5A5A));
		issue(make_req(OP_POP_HI, '0, '0));
		issue(make_req(OP_POP_LO, '0, '0));
		issue(make_req(OP_INSERT, 24'h7FFFFF, 24'h0F0F0F));
		issue(make_req(OP_POP_LO, '0, '0));
		issue(make_req(OP_POP_HI, '0, '0));
		issue(make_req(OP_POP_LO, '0, '0));
		issue(make_req(OP_POP_HI, '0, '0));
		directed_count = sent;
		drain();

		// Small store with plenty of empty removals and back-to-back requests.
		idle_pct = 0;
		run_mix(250, 50);
		drain();

		// Fill to capacity with fresh keys, then knock on the full store, including
		// with keys that may include a held one.
		idle_pct = 30;
		while (sb.held() < CAP)
			issue(make_req(OP_INSERT, KEY_W'($urandom()), VAL_W'($urandom())));
		repeat (8) issue(make_req(OP_INSERT, pick_key(), VAL_W'($urandom())));

		// Churn around the full mark with a sparse sender.
		idle_pct = 88;
		run_mix(120, 48);
		drain();

		// Mostly removals from both ends with no idling.
		idle_pct = 0;
		run_mix(200, 20);
		drain();

		sb.close_out();
		$display("Sent %0d requests (%0d directed), store filled to %0d of %0d entries.",
			sent, directed_count, sb.peak, CAP);
		$display("Results seen: %0d ok, %0d empty, %0d full, %0d duplicate.",
			sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_FULL],
			sb.status_hits[ST_DUP]);
		if (sb.mismatches == 0)
			$display("PASS double_ended_priority_queue");
		else
			$display("FAIL double_ended_priority_queue");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL double_ended_priority_queue");
		$finish;
	end

endmodule

[files.f]
rtl/depq_pkg.sv
rtl/depq_cell.sv
rtl/double_ended_priority_queue.sv
tb/sv/testbench.sv
